### src/hnbt_pkg.sv
// ---------------------------------------------------------------------------
// hnbt_pkg: shared types and constants
// Command codes, the queued command record and frame-check constants for the
// HDLC NRZI bit-stuffing transmitter.
// ---------------------------------------------------------------------------
`default_nettype none

package hnbt_pkg;

   typedef enum logic [1:0] {
      FUNC_DATA     = 2'd0,  // byte sent with bit stuffing
      FUNC_RAW      = 2'd1,  // byte sent as is (flags)
      FUNC_CHK_RST  = 2'd2,  // preset frame check
      FUNC_CHK_EMIT = 2'd3   // send complemented frame check, low byte first
   } func_type;

   typedef struct packed {
      func_type   func;
      logic [7:0] data;
   } cmd_type;

   localparam logic [15:0] CHECK_POLY   = 16'h8408;
   localparam logic [15:0] CHECK_PRESET = 16'hFFFF;
   localparam logic [2:0]  RUN_MAX      = 3'd7;
   localparam logic [2:0]  RUN_LIMIT    = 3'd5;
   localparam logic [4:0]  BYTE_BITS    = 5'd8;
   localparam logic [4:0]  CHECK_BITS   = 5'd16;

endpackage

`default_nettype wire

### src/hnbt_front.sv
// ---------------------------------------------------------------------------
// hnbt_front: command intake and queue
// Accepts request transfers, packs them into command records and holds them
// in a short queue for the serializer.
// ---------------------------------------------------------------------------
`default_nettype none

module hnbt_front
   import hnbt_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_func,
   input  wire logic [7:0] req_data_byte,
   output logic            cmd_valid,
   output cmd_type         cmd,
   input  wire logic       cmd_pop
);

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(QUEUE_DEPTH);

   cmd_type         slot_ff [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            push;
   logic            pop;

   assign req_ready = (count_ff != CntFull);
   assign cmd_valid = (count_ff != '0);
   assign cmd       = slot_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_pop && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{func: func_type'(req_func), data: req_data_byte};
      end
   end

endmodule

`default_nettype wire

### src/hnbt_back.sv
// ---------------------------------------------------------------------------
// hnbt_back: bit serializer
// Shifts bytes out LSB first, runs the CRC-16, inserts stuffing bits and
// NRZI-codes the line, one bit per cycle unless stalled, into an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module hnbt_back
   import hnbt_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic cmd_valid,
   input  cmd_type   cmd,
   output logic      cmd_pop,
   output logic      rsp_valid,
   input  wire logic rsp_ready,
   output logic      rsp_line_bit,
   output logic      rsp_stuffed,
   output logic      rsp_last
);

   logic [15:0] check_ff, check_in;
   logic        tone_ff, tone_in;
   logic [2:0]  run_ff, run_in;
   logic [15:0] shreg_ff, shreg_in;
   logic [4:0]  left_ff, left_in;     // data bits still to send
   logic        stuff_en_ff, stuff_en_in;
   logic        pend_ff, pend_in;     // stuffing bit owed

   logic        out_valid_ff, out_valid_in;
   logic        out_bit_ff, out_bit_in;
   logic        out_stuffed_ff, out_stuffed_in;
   logic        out_last_ff, out_last_in;

   logic        has_bit;
   logic        advance;
   logic        cur_bit;
   logic [2:0]  run_sat;
   logic        bit_val;
   logic        bit_stuffed;
   logic        bit_last;

   assign has_bit = pend_ff || (left_ff != '0);
   assign advance = has_bit && (!out_valid_ff || rsp_ready);
   assign cur_bit = shreg_ff[0];
   assign run_sat = (run_ff == RUN_MAX) ? RUN_MAX : run_ff + 3'd1;

   always_comb begin
      check_in    = check_ff;
      tone_in     = tone_ff;
      run_in      = run_ff;
      shreg_in    = shreg_ff;
      left_in     = left_ff;
      stuff_en_in = stuff_en_ff;
      pend_in     = pend_ff;
      bit_val     = 1'b0;
      bit_stuffed = 1'b0;
      bit_last    = 1'b0;
      cmd_pop     = 1'b0;

      if (advance) begin
         if (pend_ff) begin
            // inserted bit: always a toggle, never enters the check
            tone_in     = ~tone_ff;
            bit_val     = ~tone_ff;
            bit_stuffed = 1'b1;
            run_in      = '0;
            pend_in     = 1'b0;
            bit_last    = (left_ff == '0);
         end else begin
            check_in = {1'b0, check_ff[15:1]}
                       ^ ((check_ff[0] ^ cur_bit) ? CHECK_POLY : 16'h0000);
            shreg_in = {1'b0, shreg_ff[15:1]};
            left_in  = left_ff - 5'd1;
            if (cur_bit) begin
               bit_val = tone_ff;
               run_in  = run_sat;
               if (stuff_en_ff && (run_sat >= RUN_LIMIT)) begin
                  pend_in  = 1'b1;
                  bit_last = 1'b0;
               end else begin
                  bit_last = (left_ff == 5'd1);
               end
            end else begin
               tone_in  = ~tone_ff;
               bit_val  = ~tone_ff;
               run_in   = '0;
               bit_last = (left_ff == 5'd1);
            end
         end
      end

      // load the next command once the current one has no bits left
      if (cmd_valid && !pend_in && (left_in == '0)) begin
         cmd_pop = 1'b1;
         unique case (cmd.func)
            FUNC_DATA, FUNC_RAW: begin
               shreg_in    = {8'h00, cmd.data};
               left_in     = BYTE_BITS;
               stuff_en_in = (cmd.func == FUNC_DATA);
            end
            FUNC_CHK_RST: begin
               check_in = CHECK_PRESET;
            end
            FUNC_CHK_EMIT: begin
               shreg_in    = ~check_in;
               left_in     = CHECK_BITS;
               stuff_en_in = 1'b1;
            end
            default: begin
               check_in = check_in;
            end
         endcase
      end
   end

   always_comb begin
      out_valid_in   = out_valid_ff;
      out_bit_in     = out_bit_ff;
      out_stuffed_in = out_stuffed_ff;
      out_last_in    = out_last_ff;
      if (advance) begin
         out_valid_in   = 1'b1;
         out_bit_in     = bit_val;
         out_stuffed_in = bit_stuffed;
         out_last_in    = bit_last;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         check_ff     <= CHECK_PRESET;
         tone_ff      <= 1'b0;
         run_ff       <= '0;
         left_ff      <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         check_ff     <= check_in;
         tone_ff      <= tone_in;
         run_ff       <= run_in;
         left_ff      <= left_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shreg_ff       <= shreg_in;
      stuff_en_ff    <= stuff_en_in;
      out_bit_ff     <= out_bit_in;
      out_stuffed_ff <= out_stuffed_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_line_bit = out_bit_ff;
   assign rsp_stuffed  = out_stuffed_ff;
   assign rsp_last     = out_last_ff;

endmodule

`default_nettype wire

### src/hdlc_nrzi_bit_stuff_transmitter.sv
// ---------------------------------------------------------------------------
// hdlc_nrzi_bit_stuff_transmitter: HDLC line-bit transmitter
// Bit stuffing, CRC-16 (0x8408) frame check and NRZI coding, one line bit
// per result transfer.
// ---------------------------------------------------------------------------
// Usage:
//   req channel: one command per transfer. req_func selects a stuffed data
//   byte, a raw byte (flags), a frame-check preset or a frame-check emit;
//   req_data_byte is used by the two byte commands only.
//   rsp channel: one line bit per transfer, rsp_stuffed marks inserted bits,
//   rsp_last marks the final bit a command produced. A check preset makes
//   no transfer.
//   Throughput: the serializer puts out one line bit per cycle while rsp_ready
//   stays high; a preset sends no line bit but still takes its turn as the
//   serializer's command load. The serializer's one-bit-per-cycle loop sets
//   the rate; the next command loads in the cycle its predecessor's last bit
//   leaves, so byte and emit commands follow with no gaps.
//   Path: when the block is idle, a command's first bit passes the queue
//   register, then the shift register, then the output register to be shown.
//   Stalls: when rsp_ready is low the output register holds its bit and the
//   serializer waits; the command queue (QUEUE_DEPTH entries) keeps taking
//   requests until it fills, then req_ready drops.
//   Reset: queue emptied, check preset to 0xFFFF, tone 0 (space), ones
//   run cleared, no result pending.
// ---------------------------------------------------------------------------
`default_nettype none

module hdlc_nrzi_bit_stuff_transmitter
   import hnbt_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_func,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic            rsp_line_bit,
   output logic            rsp_stuffed,
   output logic            rsp_last
);

   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;

   // front: intake and command queue
   hnbt_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_data_byte (req_data_byte),
      .cmd_valid     (cmd_valid),
      .cmd           (cmd),
      .cmd_pop       (cmd_pop)
   );

   // back: serializer, check, stuffing, NRZI and output register
   hnbt_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd),
      .cmd_pop      (cmd_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_line_bit (rsp_line_bit),
      .rsp_stuffed  (rsp_stuffed),
      .rsp_last     (rsp_last)
   );

endmodule

`default_nettype wire

### src/hnbt_checker.sv
// ---------------------------------------------------------------------------
// hnbt_checker: port-level checks
// Watches the transmitter's ports for handshake and line-coding slips.
// ---------------------------------------------------------------------------
`default_nettype none

module hnbt_checker
   import hnbt_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic [1:0] req_func,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       rsp_line_bit,
   input wire logic       rsp_stuffed,
   input wire logic       rsp_last
);

   logic prev_line_ff;
   logic req_seen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_line_ff <= 1'b0;
         req_seen_ff  <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            prev_line_ff <= rsp_line_bit;
         end
         if (req_valid && req_ready && (func_type'(req_func) != FUNC_CHK_RST)) begin
            req_seen_ff <= 1'b1;
         end
      end
   end

   // a held result keeps its valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // a held result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable({rsp_line_bit, rsp_stuffed, rsp_last}))
      else $error("rsp payload changed while stalled");

   // an inserted bit always toggles the line
   a_stuff_toggles: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_stuffed |-> rsp_line_bit != prev_line_ff)
      else $error("stuffing bit did not toggle the line");

   // no line bit without a byte or emit command taken first
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_seen_ff)
      else $error("result shown with no command accepted");

endmodule

bind hdlc_nrzi_bit_stuff_transmitter hnbt_checker u_hnbt_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_func      (req_func),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_line_bit  (rsp_line_bit),
   .rsp_stuffed   (rsp_stuffed),
   .rsp_last      (rsp_last)
);

`default_nettype wire
